@@ design/snasb_pkg.sv @@
`default_nettype none

package snasb_pkg;

    typedef enum logic [2:0] {
        KIND_READ32  = 3'd0,
        KIND_READ16  = 3'd1,
        KIND_READ8   = 3'd2,
        KIND_WRITE32 = 3'd3,
        KIND_WRITE16 = 3'd4,
        KIND_WRITE8  = 3'd5
    } kind_t;

    localparam logic [7:0]  REG_BLOCK_SIZE  = 8'h04;
    localparam logic [7:0]  REG_BLOCK_COUNT = 8'h06;
    localparam logic [7:0]  REG_XFER_MODE   = 8'h0C;
    localparam logic [7:0]  REG_COMMAND     = 8'h0E;
    localparam logic [31:0] HALF_MASK       = 32'h0000_ffff;
    localparam logic [31:0] BYTE_MASK       = 32'h0000_00ff;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  offset;
        logic [31:0] write_data;
        logic [31:0] current_word;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        bus_write;
        logic [7:0]  bus_address;
        logic [31:0] bus_data;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic emit;
        logic consume;
    } step_t;

endpackage

`default_nettype wire

@@ design/snasb_in_stage.sv @@
`default_nettype none

module snasb_in_stage
    import snasb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire req_t in_req,
    input  wire logic consume,
    output logic      req_valid,
    output req_t      req
);

    logic req_valid_reg;
    logic req_valid_next;
    req_t req_reg;
    req_t req_next;

    assign in_ready = !req_valid_reg || consume;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        req_next       = req_reg;
        if (in_valid && in_ready)
        begin
            req_valid_next = 1'b1;
            req_next       = in_req;
        end
        else if (consume)
        begin
            req_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

    assign req_valid = req_valid_reg;
    assign req       = req_reg;

endmodule

`default_nettype wire

@@ design/snasb_engine.sv @@
`default_nettype none

module snasb_engine
    import snasb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    input  wire req_t req,
    input  wire logic out_ready,
    output rsp_t      rsp,
    output step_t     step
);

    logic [31:0] command_shadow_reg;
    logic [31:0] command_shadow_next;
    logic [31:0] block_shadow_reg;
    logic [31:0] block_shadow_next;
    logic        command_pending_reg;
    logic        command_pending_next;
    logic        block_pending_reg;
    logic        block_pending_next;

    logic [4:0]  shift;
    logic [7:0]  aligned;
    logic        is_blk;
    logic [31:0] read_src;
    logic [31:0] write_src;
    logic [31:0] half_read;
    logic [31:0] byte_read;
    logic [31:0] half_merged;
    logic [31:0] cmd_merged;
    logic [31:0] byte_merged;

    function automatic logic [31:0] lane_merge(
        input logic [31:0] old_word,
        input logic [31:0] value,
        input logic [31:0] lane_mask,
        input logic [4:0]  lane_shift
    );
        logic [31:0] m;
        m = lane_mask << lane_shift;
        lane_merge = (old_word & ~m) | (((value & lane_mask) << lane_shift) & m);
    endfunction

    assign shift   = {req.offset[1:0], 3'b000};
    assign aligned = {req.offset[7:2], 2'b00};
    assign is_blk  = (req.offset == REG_BLOCK_SIZE) || (req.offset == REG_BLOCK_COUNT);

    always_comb
    begin
        if ((req.offset == REG_XFER_MODE) && command_pending_reg)
        begin
            read_src = command_shadow_reg;
        end
        else if (is_blk && block_pending_reg)
        begin
            read_src = block_shadow_reg;
        end
        else
        begin
            read_src = req.current_word;
        end
    end

    assign write_src   = (is_blk && block_pending_reg) ? block_shadow_reg : req.current_word;
    assign half_read   = (read_src >> shift) & HALF_MASK;
    assign byte_read   = (req.current_word >> shift) & BYTE_MASK;
    assign half_merged = lane_merge(write_src, req.write_data, HALF_MASK, shift);
    assign cmd_merged  = lane_merge(command_shadow_reg, req.write_data, HALF_MASK, shift);
    assign byte_merged = lane_merge(req.current_word, req.write_data, BYTE_MASK, shift);

    always_comb
    begin
        rsp                  = '0;
        rsp.last             = 1'b1;
        command_shadow_next  = command_shadow_reg;
        block_shadow_next    = block_shadow_reg;
        command_pending_next = command_pending_reg;
        block_pending_next   = block_pending_reg;
        case (req.kind)
            KIND_READ32:
            begin
                rsp.read_data = req.current_word;
            end
            KIND_READ16:
            begin
                rsp.read_data = half_read;
            end
            KIND_READ8:
            begin
                rsp.read_data = byte_read;
            end
            KIND_WRITE32:
            begin
                rsp.bus_write   = 1'b1;
                rsp.bus_address = aligned;
                rsp.bus_data    = req.write_data;
            end
            KIND_WRITE16:
            begin
                if (req.offset == REG_COMMAND)
                begin
                    rsp.bus_write = 1'b1;
                    if (block_pending_reg)
                    begin
                        // The held block word goes out first; the item stays for the command.
                        rsp.bus_address    = REG_BLOCK_SIZE;
                        rsp.bus_data       = block_shadow_reg;
                        rsp.last           = 1'b0;
                        block_pending_next = 1'b0;
                    end
                    else
                    begin
                        rsp.bus_address      = aligned;
                        rsp.bus_data         = cmd_merged;
                        command_pending_next = 1'b0;
                    end
                end
                else if (req.offset == REG_XFER_MODE)
                begin
                    command_shadow_next  = half_merged;
                    command_pending_next = 1'b1;
                end
                else if (is_blk)
                begin
                    block_shadow_next  = half_merged;
                    block_pending_next = 1'b1;
                end
                else
                begin
                    rsp.bus_write   = 1'b1;
                    rsp.bus_address = aligned;
                    rsp.bus_data    = half_merged;
                end
            end
            KIND_WRITE8:
            begin
                rsp.bus_write   = 1'b1;
                rsp.bus_address = aligned;
                rsp.bus_data    = byte_merged;
            end
            default:
            begin
            end
        endcase
    end

    assign step.emit    = req_valid && out_ready;
    assign step.consume = step.emit && rsp.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_shadow_reg  <= '0;
            block_shadow_reg    <= '0;
            command_pending_reg <= 1'b0;
            block_pending_reg   <= 1'b0;
        end
        else if (step.emit)
        begin
            command_shadow_reg  <= command_shadow_next;
            block_shadow_reg    <= block_shadow_next;
            command_pending_reg <= command_pending_next;
            block_pending_reg   <= block_pending_next;
        end
    end

    // A result that is not the last one is always the flush of the block word.
    assert property (@(posedge clk) disable iff (!rst_n)
        step.emit && !rsp.last |-> rsp.bus_write && (rsp.bus_address == REG_BLOCK_SIZE))
        else $error("non-final result is not a block word flush");

    // After the flush, the block word is no longer pending and the same item is still held.
    assert property (@(posedge clk) disable iff (!rst_n)
        step.emit && !rsp.last |=> !block_pending_reg && req_valid)
        else $error("block flush left the block word pending or dropped the item");

    // The command write always clears the held command word.
    assert property (@(posedge clk) disable iff (!rst_n)
        step.emit && rsp.last && (req.kind == KIND_WRITE16) && (req.offset == REG_COMMAND)
        |=> !command_pending_reg)
        else $error("command write left the command word pending");

endmodule

`default_nettype wire

@@ design/snasb_out_stage.sv @@
`default_nettype none

module snasb_out_stage
    import snasb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic load,
    input  wire rsp_t rsp,
    output logic      load_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output rsp_t      out_rsp
);

    logic out_valid_reg;
    logic out_valid_next;
    rsp_t out_rsp_reg;

    assign load_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_rsp_reg <= rsp;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rsp   = out_rsp_reg;

endmodule

`default_nettype wire

@@ design/sdhci_narrow_access_shadow_bridge_core.sv @@
// An accepted item waits in the input register while the engine forms its result, which is
// loaded into the output register that drives m_axis_tvalid and the result ports.
// One item per cycle while the output can load; a command write that flushes a held block
// word gives two results and keeps its item in the input register, so the input stalls.
// Reset clears both shadow words, both pending flags and all valid flags at once.
`default_nettype none

module sdhci_narrow_access_shadow_bridge_core
    import snasb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // offset, write_data, current_word
    input  wire logic [2:0]  s_axis_tuser,  // kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,       // read_data, bus_address, bus_data
    output logic             m_axis_tuser,  // bus_write
    output logic             m_axis_tlast
);

    req_t  in_req;
    req_t  req;
    logic  req_valid;
    rsp_t  rsp;
    rsp_t  out_rsp;
    step_t step;
    logic  load_ready;

    assign in_req.kind         = kind_t'(s_axis_tuser);
    assign in_req.offset       = s_axis_tdata[7:0];
    assign in_req.write_data   = s_axis_tdata[39:8];
    assign in_req.current_word = s_axis_tdata[71:40];

    snasb_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_req    (in_req),
        .consume   (step.consume),
        .req_valid (req_valid),
        .req       (req)
    );

    snasb_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .out_ready (load_ready),
        .rsp       (rsp),
        .step      (step)
    );

    snasb_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step.emit),
        .rsp        (rsp),
        .load_ready (load_ready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_rsp    (out_rsp)
    );

    assign m_axis_tdata = {out_rsp.bus_data, out_rsp.bus_address, out_rsp.read_data};
    assign m_axis_tuser = out_rsp.bus_write;
    assign m_axis_tlast = out_rsp.last;

    // The second result of a command write follows its first transfer directly.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
        else $error("command write did not follow the block word flush");

endmodule

`default_nettype wire

@@ bench/sdhci_narrow_access_shadow_bridge_core_tb.sv @@
`timescale 1ns / 100ps

module sdhci_narrow_access_shadow_bridge_core_tb;
    import snasb_pkg::*;

    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS = 950;
    localparam int BURST_ITEMS = 150;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    logic [31:0] cmd_shadow;
    logic [31:0] blk_shadow;
    logic        cmd_pending;
    logic        blk_pending;
    rsp_t        due_responses[$];

    int mismatches;
    int items_sent;
    int results_seen;
    int cycles;
    int command_writes;
    int flush_writes;
    int held_writes;
    bit tx_idle_on;
    bit rx_idle_on;
    int rx_hold;

    sdhci_narrow_access_shadow_bridge_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rand_word();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return 32'h0000_0000;
        if (pick == 1)
            return 32'hffff_ffff;
        return $urandom();
    endfunction

    function automatic logic [31:0] lane_merge(logic [31:0] old_word, logic [31:0] value,
                                               logic [31:0] lane, logic [4:0] shift);
        logic [31:0] sel;
        sel = lane << shift;
        return (old_word & ~sel) | (((value & lane) << shift) & sel);
    endfunction

    // Works out the results of one accepted access and updates the shadow state.
    function automatic void bridge_access(logic [2:0] kind, logic [7:0] off,
                                          logic [31:0] wdata, logic [31:0] cur);
        logic [4:0]  shift;
        logic [7:0]  aligned;
        logic        is_blk;
        logic [31:0] src;
        logic [31:0] merged;
        rsp_t        flush;
        rsp_t        r;
        shift = {off[1:0], 3'b000};
        aligned = {off[7:2], 2'b00};
        is_blk = (off == REG_BLOCK_SIZE) || (off == REG_BLOCK_COUNT);
        r = '0;
        r.last = 1'b1;
        case (kind)
            KIND_READ32:
                r.read_data = cur;
            KIND_READ16:
            begin
                src = cur;
                if (off == REG_XFER_MODE && cmd_pending)
                    src = cmd_shadow;
                else if (is_blk && blk_pending)
                    src = blk_shadow;
                r.read_data = (src >> shift) & HALF_MASK;
            end
            KIND_READ8:
                r.read_data = (cur >> shift) & BYTE_MASK;
            KIND_WRITE32:
            begin
                r.bus_write = 1'b1;
                r.bus_address = aligned;
                r.bus_data = wdata;
            end
            KIND_WRITE16:
            begin
                if (off == REG_COMMAND)
                begin
                    command_writes++;
                    if (blk_pending)
                    begin
                        flush = '0;
                        flush.bus_write = 1'b1;
                        flush.bus_address = REG_BLOCK_SIZE;
                        flush.bus_data = blk_shadow;
                        due_responses.push_back(flush);
                        blk_pending = 1'b0;
                        flush_writes++;
                    end
                    cmd_pending = 1'b0;
                    r.bus_write = 1'b1;
                    r.bus_address = aligned;
                    r.bus_data = lane_merge(cmd_shadow, wdata, HALF_MASK, shift);
                end
                else
                begin
                    src = (is_blk && blk_pending) ? blk_shadow : cur;
                    merged = lane_merge(src, wdata, HALF_MASK, shift);
                    if (off == REG_XFER_MODE)
                    begin
                        cmd_shadow = merged;
                        cmd_pending = 1'b1;
                        held_writes++;
                    end
                    else if (is_blk)
                    begin
                        blk_shadow = merged;
                        blk_pending = 1'b1;
                        held_writes++;
                    end
                    else
                    begin
                        r.bus_write = 1'b1;
                        r.bus_address = aligned;
                        r.bus_data = merged;
                    end
                end
            end
            KIND_WRITE8:
            begin
                r.bus_write = 1'b1;
                r.bus_address = aligned;
                r.bus_data = lane_merge(cur, wdata, BYTE_MASK, shift);
            end
            default:
                r = r;
        endcase
        due_responses.push_back(r);
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch: expected 0x%08h, got 0x%08h", $realtime, what, want, got);
    endtask

    task automatic send_item(input logic [2:0] kind, input logic [7:0] off,
                             input logic [31:0] wdata, input logic [31:0] cur);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {cur, wdata, off};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bridge_access(kind, off, wdata, cur);
        items_sent++;
        gap = tx_idle_on ? gap_length() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (due_responses.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_command_sequence();
        logic [7:0] blk_reg;
        blk_reg = ($urandom_range(0, 1) == 0) ? REG_BLOCK_SIZE : REG_BLOCK_COUNT;
        if ($urandom_range(0, 2) != 0)
            send_item(KIND_WRITE16, REG_BLOCK_SIZE, $urandom(), rand_word());
        if ($urandom_range(0, 2) != 0)
            send_item(KIND_WRITE16, REG_BLOCK_COUNT, $urandom(), rand_word());
        if ($urandom_range(0, 3) == 0)
            send_item(KIND_READ16, blk_reg, $urandom(), rand_word());
        if ($urandom_range(0, 4) != 0)
            send_item(KIND_WRITE16, REG_XFER_MODE, $urandom(), rand_word());
        if ($urandom_range(0, 3) == 0)
            send_item(KIND_READ16, REG_XFER_MODE, $urandom(), rand_word());
        send_item(KIND_WRITE16, REG_COMMAND, $urandom(), rand_word());
    endtask

    task automatic send_noise_item();
        logic [2:0] kind;
        logic [7:0] off;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 18)
            kind = 3'(pick % 6);
        else
            kind = (pick == 18) ? KIND_SPARE_6 : KIND_SPARE_7;
        if ($urandom_range(0, 1) == 0)
            off = 8'($urandom_range(0, 255));
        else
            off = 8'($urandom_range(0, 15));
        send_item(kind, off, $urandom(), rand_word());
    endtask

    task automatic test_lane_reads();
        send_item(KIND_READ32, 8'h00, 32'h0000_0000, 32'hffff_ffff);
        send_item(KIND_READ32, 8'hff, 32'hffff_ffff, 32'ha5c3_0f96);
        send_item(KIND_READ16, 8'h01, 32'h0000_0000, 32'h8765_4321);
        send_item(KIND_READ16, 8'h02, 32'h0000_0000, 32'h8765_4321);
        send_item(KIND_READ16, 8'h03, 32'h0000_0000, 32'hffff_ffff);
        send_item(KIND_READ8, 8'h00, 32'h0000_0000, 32'h4433_2211);
        send_item(KIND_READ8, 8'h01, 32'h0000_0000, 32'h4433_2211);
        send_item(KIND_READ8, 8'h02, 32'h0000_0000, 32'h4433_2211);
        send_item(KIND_READ8, 8'hfb, 32'h0000_0000, 32'h4433_2211);
    endtask

    task automatic test_shadow_and_command();
        send_item(KIND_READ16, REG_XFER_MODE, 32'h0000_0000, 32'h1111_2222);
        send_item(KIND_WRITE16, REG_XFER_MODE, 32'hffff_1234, 32'hcafe_0000);
        send_item(KIND_READ16, REG_XFER_MODE, 32'h0000_0000, 32'h0000_0000);
        send_item(KIND_READ16, REG_COMMAND, 32'h0000_0000, 32'h7777_8888);
        send_item(KIND_WRITE16, REG_BLOCK_SIZE, 32'h0000_0200, 32'hffff_ffff);
        send_item(KIND_WRITE16, REG_BLOCK_COUNT, 32'h0001_0010, 32'h0000_0000);
        send_item(KIND_READ16, REG_BLOCK_SIZE, 32'h0000_0000, 32'h0000_0000);
        send_item(KIND_READ16, REG_BLOCK_COUNT, 32'h0000_0000, 32'h0000_0000);
        send_item(KIND_READ8, REG_BLOCK_SIZE, 32'h0000_0000, 32'h5566_7788);
        send_item(KIND_WRITE16, REG_COMMAND, 32'h0000_ffff, 32'h0000_0000);
        send_item(KIND_WRITE16, REG_COMMAND, 32'hffff_0000, 32'hffff_ffff);
        send_item(KIND_WRITE32, 8'h07, 32'hdead_beef, 32'h0000_0000);
        send_item(KIND_WRITE8, 8'hff, 32'hffff_ff5a, 32'h0000_0000);
        send_item(KIND_WRITE16, 8'h03, 32'h0000_abcd, 32'h0000_0000);
        send_item(KIND_WRITE16, 8'hfe, 32'hffff_ffff, 32'h0000_0000);
        send_item(KIND_SPARE_6, 8'h0c, 32'hffff_ffff, 32'hffff_ffff);
        send_item(KIND_SPARE_7, 8'h0e, 32'hffff_ffff, 32'hffff_ffff);
    endtask

    task automatic test_random_traffic(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 9) < 6)
                send_command_sequence();
            else
                send_noise_item();
        end
    endtask

    task automatic test_drain_pause();
        repeat (10) send_command_sequence();
        s_axis_tvalid <= 1'b0;
        wait_drained();
        send_item(KIND_READ16, REG_XFER_MODE, $urandom(), rand_word());
        send_command_sequence();
    endtask

    task automatic test_back_to_back(input int count);
        int target;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        target = items_sent + count;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 1) == 0)
                send_command_sequence();
            else
                send_noise_item();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if (rx_idle_on && $urandom_range(0, 3) == 0)
        begin
            rx_hold <= gap_length();
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        rsp_t got;
        rsp_t want;
        got.read_data = m_axis_tdata[31:0];
        got.bus_address = m_axis_tdata[39:32];
        got.bus_data = m_axis_tdata[71:40];
        got.bus_write = m_axis_tuser;
        got.last = m_axis_tlast;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (due_responses.size() == 0)
                note_mismatch("unexpected result, read_data", 32'h0, got.read_data);
            else
            begin
                want = due_responses.pop_front();
                if (got.read_data !== want.read_data)
                    note_mismatch("read_data", want.read_data, got.read_data);
                if (got.bus_write !== want.bus_write)
                    note_mismatch("bus_write", 32'(want.bus_write), 32'(got.bus_write));
                if (got.bus_address !== want.bus_address)
                    note_mismatch("bus_address", 32'(want.bus_address), 32'(got.bus_address));
                if (got.bus_data !== want.bus_data)
                    note_mismatch("bus_data", want.bus_data, got.bus_data);
                if (got.last !== want.last)
                    note_mismatch("last", 32'(want.last), 32'(got.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycles, due_responses.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        rx_hold = 0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        cmd_shadow = '0;
        blk_shadow = '0;
        cmd_pending = 1'b0;
        blk_pending = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_lane_reads();
        test_shadow_and_command();
        test_random_traffic(RANDOM_ITEMS / 2);
        test_drain_pause();
        test_back_to_back(BURST_ITEMS);
        test_random_traffic(RANDOM_ITEMS - RANDOM_ITEMS / 2 - BURST_ITEMS);

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d register accesses and checked %0d results.", items_sent, results_seen);
        $display("Saw %0d command writes (%0d with a block word flush) and %0d held writes.",
                 command_writes, flush_writes, held_writes);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            $display("%0d mismatches in total.", mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
